// ===== hw/rtl/lsxd_pkg.sv =====
// shared constants for the lcg seeded xor stream decrypt unit
package lsxd_pkg;

  // key table size default
  localparam int KEY_TABLE_WORDS_DEF = 256;

  // linear congruential schedule
  localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [31:0] LCG_ADD = 32'h0000_3039;

  // index stepping
  localparam logic [7:0] INDEX_WRAP = 8'hF9;
  localparam logic [7:0] LAG_START  = 8'h67;

  // first plain byte of a file
  localparam logic [7:0] MARKER = 8'h01;

  // header length in bytes
  localparam logic [2:0] SEED_BYTES = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_MARK  = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

endpackage

// ===== hw/rtl/lsxd_ram.sv =====
// generic ram: one write port, two registered read ports
module lsxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/lcg_seeded_xor_stream_decrypt_unit.sv =====
// top level of the lcg seeded xor stream decrypt unit
//
// Input channel: one file byte per request (data_byte, first_byte,
// last_byte) on in_valid / in_stall. Output channel: one result per payload
// byte (plain_byte, end_of_file, status) on out_valid / out_stall.
// The first four bytes of a file form the seed and give no result, unless
// the file ends inside them: then one result with status too short.
// After the fourth seed byte (unless it ends the file) the key table is
// filled by the lcg engine, one multiply per cycle, two per entry but one for
// the last: in_stall stays high for the whole fill, once per file.
// Payload bytes then stream at one byte per cycle while the receiver takes
// them; a result is read from the table into the read stage when its request
// is taken, then the read-modify-write of the lead entry moves it to out_valid.
// When the receiver stalls, the held result stays put, one more byte waits
// in the read stage, and in_stall rises until the output is taken.
// Reset clears the per-file state and the pipeline; the key table holds
// no defined contents until the first seed has been taken.
module lcg_seeded_xor_stream_decrypt_unit #(
  parameter int KEY_TABLE_WORDS = lsxd_pkg::KEY_TABLE_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] plain_byte,
  output logic       end_of_file,
  output logic [1:0] status
);
  import lsxd_pkg::*;

  localparam int IDX_W = $clog2(KEY_TABLE_WORDS);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(KEY_TABLE_WORDS - 1);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_FILL = 1'b1;

  // per-file state
  logic        state;
  logic [7:0]  lead_index;
  logic [7:0]  lag_index;
  logic [31:0] seed_word;
  logic [2:0]  header_count;
  logic        awaiting_marker;

  // fill engine
  logic [31:0]      lcg;
  logic             fill_phase;
  logic [IDX_W-1:0] fill_idx;

  // read stage
  logic             p1_valid;
  logic             p1_short;
  logic [7:0]       p1_data;
  logic             p1_last;
  logic             p1_mark;
  logic [IDX_W-1:0] p1_addr;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       rd_lead;
  logic [7:0]       rd_lag;

  logic        in_accept;
  logic        out_free;
  logic        p1_move;
  logic        fill_step;
  logic        fill_we;
  logic [31:0] lcg_next;
  logic [7:0]  key_new;
  logic [7:0]  plain_new;

  logic [2:0]  hc_eff;
  logic [31:0] seed_eff;
  logic [31:0] seed_new;
  logic [7:0]  lead_eff;
  logic [7:0]  lag_eff;
  logic        await_eff;
  logic        is_header;

  // handshake
  always_comb begin
    out_free  = !out_valid || !out_stall;
    p1_move   = p1_valid && out_free;
    in_stall  = (state == ST_FILL) || (p1_valid && !out_free);
    in_accept = in_valid && !in_stall;
  end

  // per-file view after an optional restart by first_byte
  always_comb begin
    hc_eff    = first_byte ? 3'd0 : header_count;
    seed_eff  = first_byte ? 32'd0 : seed_word;
    lead_eff  = first_byte ? 8'd0 : lead_index;
    lag_eff   = first_byte ? LAG_START : lag_index;
    await_eff = first_byte ? 1'b1 : awaiting_marker;
    is_header = hc_eff < SEED_BYTES;
    seed_new  = seed_eff | ({24'd0, data_byte} << {hc_eff[1:0], 3'b000});
  end

  // lcg step and table write
  always_comb begin
    lcg_next  = lcg * LCG_MUL + LCG_ADD;
    fill_step = (state == ST_FILL) && !p1_valid;
    fill_we   = fill_step && !fill_phase;
    key_new   = rd_lead ^ rd_lag;
    plain_new = p1_data ^ key_new;
    ram_we    = fill_we || (p1_move && !p1_short);
    ram_waddr = fill_we ? fill_idx : p1_addr;
    ram_wdata = fill_we ? lcg_next[23:16] : key_new;
  end

  lsxd_ram #(
    .WIDTH (8),
    .DEPTH (KEY_TABLE_WORDS)
  ) u_key_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (in_accept),
    .raddr_a (lead_eff[IDX_W-1:0]),
    .raddr_b (lag_eff[IDX_W-1:0]),
    .rdata_a (rd_lead),
    .rdata_b (rd_lag)
  );

  // per-file control and fill sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_RUN;
      lead_index      <= 8'd0;
      lag_index       <= LAG_START;
      seed_word       <= 32'd0;
      header_count    <= 3'd0;
      awaiting_marker <= 1'b1;
      fill_phase      <= 1'b0;
      fill_idx        <= '0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (in_accept) begin
            if (last_byte) begin
              lead_index      <= 8'd0;
              lag_index       <= LAG_START;
              seed_word       <= 32'd0;
              header_count    <= 3'd0;
              awaiting_marker <= 1'b1;
            end else if (is_header) begin
              lead_index      <= lead_eff;
              lag_index       <= lag_eff;
              seed_word       <= seed_new;
              header_count    <= hc_eff + 3'd1;
              awaiting_marker <= await_eff;
              if (hc_eff == SEED_BYTES - 3'd1) begin
                state      <= ST_FILL;
                fill_phase <= 1'b0;
                fill_idx   <= '0;
              end
            end else begin
              lead_index      <= (lead_eff == INDEX_WRAP - 8'd1) ? 8'd0 : lead_eff + 8'd1;
              lag_index       <= (lag_eff == INDEX_WRAP - 8'd1) ? 8'd0 : lag_eff + 8'd1;
              seed_word       <= seed_eff;
              header_count    <= hc_eff;
              awaiting_marker <= 1'b0;
            end
          end
        end
        ST_FILL: begin
          if (fill_step) begin
            fill_phase <= !fill_phase;
            if (!fill_phase) begin
              if (fill_idx == LAST_ENTRY) begin
                state <= ST_RUN;
              end
            end else begin
              fill_idx <= fill_idx + 1'b1;
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // lcg register: loaded with the seed, stepped once per fill cycle
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      lcg <= seed_new;
    end else if (fill_step) begin
      lcg <= lcg_next;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (in_accept) begin
      p1_valid <= !is_header || last_byte;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_short <= is_header;
      p1_data  <= data_byte;
      p1_last  <= last_byte;
      p1_mark  <= await_eff;
      p1_addr  <= lead_eff[IDX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      if (p1_short) begin
        plain_byte  <= 8'd0;
        end_of_file <= 1'b1;
        status      <= STATUS_TOO_SHORT;
      end else begin
        plain_byte  <= plain_new;
        end_of_file <= p1_last;
        status      <= (p1_mark && plain_new != MARKER) ? STATUS_BAD_MARK : STATUS_OK;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the lcg seeded xor stream decrypt unit
module tb;
  import lsxd_pkg::*;

  localparam int KEY_TABLE_WORDS = KEY_TABLE_WORDS_DEF;
  localparam int ITEMS = 1750;
  localparam int QUIET_LIMIT = 4000;
  localparam int DIR_N = 26;

  // one result of the block
  typedef struct packed {
    logic [7:0] plain;
    logic       eof;
    logic [1:0] stat;
  } plain_res_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_MARKER
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    plain_res_t want;
  } stim_row_t;

  localparam plain_res_t NO_TYPED = '0;
  localparam plain_res_t TOO_SHORT = {8'h00, 1'b1, STATUS_TOO_SHORT};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       first_byte = 1'b0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] plain_byte;
  logic       end_of_file;
  logic [1:0] status;

  // predictor state
  logic [7:0]  key_tab [KEY_TABLE_WORDS];
  logic [7:0]  lead_ix;
  logic [7:0]  lag_ix;
  logic [31:0] seed_acc;
  logic [2:0]  seed_cnt;
  logic        want_marker;

  plain_res_t plain_q [$];
  int         items_sent = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  bit         idle_on = 1'b0;

  // directed requests: short files, zero seed, marker hit, restarts
  stim_row_t dir_rows [DIR_N] = '{
    // one-byte file
    {ROW_TYPED,   8'hFF, 1'b1, 1'b1, TOO_SHORT},
    // file ends on third seed byte
    {ROW_PREDICT, 8'h00, 1'b1, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_TYPED,   8'h00, 1'b0, 1'b1, TOO_SHORT},
    // file ends on fourth seed byte, so the block skips the table fill
    {ROW_PREDICT, 8'h00, 1'b1, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_TYPED,   8'h00, 1'b0, 1'b1, TOO_SHORT},
    // zero seed, first plain byte hits the marker
    {ROW_PREDICT, 8'h00, 1'b1, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_MARKER,  8'h00, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'hFF, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h00, 1'b0, 1'b1, NO_TYPED},
    // next file with no first flag, dropped mid payload
    {ROW_PREDICT, 8'h78, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h56, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h34, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h12, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'hFF, 1'b0, 1'b0, NO_TYPED},
    // new file dropped inside its seed
    {ROW_PREDICT, 8'hFF, 1'b1, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'hAA, 1'b1, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h55, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'hA5, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h5A, 1'b0, 1'b0, NO_TYPED},
    {ROW_PREDICT, 8'h80, 1'b0, 1'b1, NO_TYPED}
  };

  lcg_seeded_xor_stream_decrypt_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plain_byte  (plain_byte),
    .end_of_file (end_of_file),
    .status      (status)
  );

  always #10 clk = ~clk;

  // per-file state back to its start values
  task automatic restart_file_state();
    lead_ix = 8'd0;
    lag_ix = LAG_START;
    seed_acc = 32'd0;
    seed_cnt = 3'd0;
    want_marker = 1'b1;
  endtask

  function automatic logic [7:0] step_ix(input logic [7:0] ix);
    logic [7:0] nxt;
    nxt = ix + 8'd1;
    return (nxt >= INDEX_WRAP) ? 8'd0 : nxt;
  endfunction

  // key byte the next payload byte will be xored with
  function automatic logic [7:0] pending_key();
    return key_tab[lead_ix] ^ key_tab[lag_ix];
  endfunction

  // decipher one accepted request, updating the predictor state
  task automatic decipher_step(input logic [7:0] d, input logic f, input logic l,
                               output bit got, output plain_res_t r);
    logic [31:0] v;
    logic [31:0] a;
    logic [31:0] b;
    got = 1'b0;
    r = '0;
    if (f) restart_file_state();
    if (seed_cnt < SEED_BYTES) begin
      seed_acc = seed_acc | ({24'd0, d} << (8 * seed_cnt));
      seed_cnt = seed_cnt + 3'd1;
      // two lcg steps per table entry, entry is bits 23..16 of the first
      if (seed_cnt == SEED_BYTES) begin
        v = seed_acc;
        for (int i = 0; i < KEY_TABLE_WORDS; i++) begin
          a = v * LCG_MUL + LCG_ADD;
          b = a * LCG_MUL + LCG_ADD;
          key_tab[i] = a[23:16];
          v = b;
        end
      end
      if (l) begin
        got = 1'b1;
        r = TOO_SHORT;
        restart_file_state();
      end
    end else begin
      key_tab[lead_ix] = key_tab[lead_ix] ^ key_tab[lag_ix];
      r.plain = d ^ key_tab[lead_ix];
      r.eof = l;
      r.stat = STATUS_OK;
      if (want_marker) begin
        if (r.plain != MARKER) r.stat = STATUS_BAD_MARK;
        want_marker = 1'b0;
      end
      lead_ix = step_ix(lead_ix);
      lag_ix = step_ix(lag_ix);
      got = 1'b1;
      if (l) restart_file_state();
    end
  endtask

  // present one request, hold it until taken, then record what it should give
  task automatic put_byte(input logic [7:0] d, input logic f, input logic l,
                          input bit typed, input plain_res_t typed_res);
    bit         got;
    plain_res_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    first_byte <= f;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    decipher_step(d, f, l, got, r);
    if (got) plain_q.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
  endtask

  // result check and receiver stall bursts
  always @(posedge clk) begin
    plain_res_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (plain_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with none pending: plain %02h eof %0b status %0d",
                     $time, plain_byte, end_of_file, status);
        end else begin
          exp_res = plain_q.pop_front();
          if (plain_byte !== exp_res.plain || end_of_file !== exp_res.eof ||
              status !== exp_res.stat) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected plain %02h eof %0b status %0d, got %02h %0b %0d",
                       $time, exp_res.plain, exp_res.eof, exp_res.stat,
                       plain_byte, end_of_file, status);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on stretches with no request or result taken
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("lcg_seeded_xor_stream_decrypt_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t  row;
    logic [7:0] d;
    logic       f;
    int         kind;
    int         n;
    bit         need_first;
    bit         drained_mid;
    need_first = 1'b1;
    drained_mid = 1'b0;
    for (int i = 0; i < KEY_TABLE_WORDS; i++) key_tab[i] = 8'h00;
    restart_file_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part
    idle_on = 1'b1;
    for (int k = 0; k < DIR_N; k++) begin
      row = dir_rows[k];
      d = row.data;
      if (row.kind == ROW_MARKER) d = MARKER ^ pending_key();
      put_byte(d, row.first, row.last, row.kind == ROW_TYPED, row.want);
    end
    drain_results();

    // random files, mostly well formed
    while (items_sent < ITEMS) begin
      idle_on = (items_sent < ITEMS - 200) && ($urandom_range(0, 3) != 0);
      if (!drained_mid && items_sent >= ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      kind = $urandom_range(0, 19);
      f = need_first || ($urandom_range(0, 4) != 0);
      if (kind == 0) begin
        // too-short file
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          put_byte(8'($urandom), (k == 0) ? f : 1'b0, k == n - 1, 1'b0, NO_TYPED);
        need_first = 1'b0;
      end else if (kind == 1) begin
        // file cut off by the next first flag
        n = $urandom_range(1, 24);
        for (int k = 0; k < n; k++)
          put_byte(8'($urandom), (k == 0) ? f : 1'b0, 1'b0, 1'b0, NO_TYPED);
        need_first = 1'b1;
      end else if (kind == 2) begin
        // noise with random flags
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          put_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                   1'b0, NO_TYPED);
        need_first = 1'b1;
      end else begin
        // seed then payload, long files wrap both table indices
        for (int k = 0; k < 4; k++)
          put_byte(8'($urandom), (k == 0) ? f : 1'b0, 1'b0, 1'b0, NO_TYPED);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 420) : $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
          d = 8'($urandom);
          if (k == 0 && $urandom_range(0, 1) == 1) d = MARKER ^ pending_key();
          put_byte(d, 1'b0, k == n - 1, 1'b0, NO_TYPED);
        end
        need_first = 1'b0;
      end
    end

    // wind down
    idle_on = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && plain_q.size() == 0)
      $display("lcg_seeded_xor_stream_decrypt_unit: match");
    else
      $display("lcg_seeded_xor_stream_decrypt_unit: mismatch");
    $finish;
  end

endmodule
